// ===== hdl/wildcard_glob_matcher_defines.svh =====
// Assertion macros used by the checker file.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WGM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/wgm_pkg.sv =====
`default_nettype none

package wgm_pkg;

    // Pattern capacity and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CHAR_W      = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // Wildcard characters
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_TEXT    = 2'd3
    } mode_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic              step_en;    // text character transfer
        logic              restart;    // reload the row from lead
        logic [LEN_W-1:0]  lead;       // leading star count after this transfer
        logic [LEN_W-1:0]  length;     // pattern length before this transfer
        logic [CHAR_W-1:0] text_char;
        logic              wr_en;      // store a pattern character
        logic [LEN_W-1:0]  wr_pos;     // 1-based cell position to write
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/wildcard_glob_matcher.sv =====
// Streaming glob matcher for '?' and '*'. Load a pattern of up to 32
// characters with append transfers, then stream text characters; every
// input transfer returns one result telling whether the text since the
// last restart matches the whole pattern, plus an overflow flag for a
// dropped pattern character. Clear, append and restart all restart the
// text. One item is taken per clock unless a held result stalls the input,
// and its result appears on the output register in the next cycle; the
// cycle time is set by the OR chain rippling through the 32 pattern cells
// when stars are present. No clearing pass is needed after reset.
`default_nettype none

module wildcard_glob_matcher (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wgm_pkg::IN_TDATA_W-1:0] s_tdata,   // [1:0] mode, [9:2] char_in
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wgm_pkg::OUT_TDATA_W-1:0]     m_tdata    // [0] matched, [1] overflow
);
    import wgm_pkg::*;

    logic              in_fire;
    mode_t             mode;
    logic [CHAR_W-1:0] char_in;

    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  lead_reg, lead_next;
    logic              row0_reg, row0_next;
    logic              out_valid_reg, out_valid_next;
    logic              matched_reg, matched_next;
    logic              ovf_reg, ovf_next;

    cell_ctrl_t        ctrl;
    logic              row_q   [MAX_PATTERN:0];
    logic              nxt     [MAX_PATTERN:0];

    assign mode     = mode_t'(s_tdata[1:0]);
    assign char_in  = s_tdata[CHAR_W+1:2];
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Pattern bookkeeping and cell control
    always_comb
    begin
        length_next    = length_reg;
        lead_next      = lead_reg;
        ovf_next       = 1'b0;
        ctrl           = '0;
        ctrl.length    = length_reg;
        ctrl.text_char = char_in;
        ctrl.wr_pos    = length_reg + LEN_W'(1);
        if (in_fire)
        begin
            case (mode)
                MODE_CLEAR:
                begin
                    length_next  = '0;
                    lead_next    = '0;
                    ctrl.restart = 1'b1;
                end
                MODE_APPEND:
                begin
                    ctrl.restart = 1'b1;
                    if (length_reg < LEN_W'(MAX_PATTERN))
                    begin
                        ctrl.wr_en  = 1'b1;
                        length_next = length_reg + LEN_W'(1);
                        if (char_in == STAR_CHAR && lead_reg == length_reg)
                            lead_next = lead_reg + LEN_W'(1);
                    end
                    else
                        ovf_next = 1'b1;
                end
                MODE_RESTART:
                    ctrl.restart = 1'b1;
                MODE_TEXT:
                    ctrl.step_en = 1'b1;
                default:
                    ctrl.step_en = 1'b0;
            endcase
        end
        ctrl.lead = lead_next;
    end

    // Column zero: set by a restart, cleared by any text character
    always_comb
    begin
        row0_next = row0_reg;
        if (ctrl.restart)
            row0_next = 1'b1;
        else if (ctrl.step_en)
            row0_next = 1'b0;
    end

    assign row_q[0] = row0_reg;
    assign nxt[0]   = 1'b0;

    // Row of pattern cells
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        wgm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (LEN_W'(g + 1)),
            .ctrl     (ctrl),
            .left_row (row_q[g]),
            .left_next(nxt[g]),
            .row      (row_q[g+1]),
            .next_bit (nxt[g+1])
        );
    end

    // Result of this transfer
    always_comb
    begin
        matched_next   = matched_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (ctrl.step_en)
                matched_next = nxt[length_reg];
            else
                matched_next = (lead_next == length_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            lead_reg      <= '0;
            row0_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            lead_reg      <= lead_next;
            row0_reg      <= row0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            matched_reg <= matched_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, ovf_reg, matched_reg};

endmodule

`default_nettype wire

// ===== hdl/wgm_cell.sv =====
`default_nettype none

module wgm_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [wgm_pkg::LEN_W-1:0] idx,        // 1-based position of this cell
    input  wire wgm_pkg::cell_ctrl_t       ctrl,
    input  wire logic                      left_row,   // row bit of the left neighbor
    input  wire logic                      left_next,  // new row bit of the left neighbor
    output logic                           row,
    output logic                           next_bit
);
    import wgm_pkg::*;

    logic              row_reg;
    logic              row_next;
    logic [CHAR_W-1:0] char_reg;
    logic              active;

    assign active = (idx <= ctrl.length);
    assign row    = row_reg;

    // DP update: star passes the chain along, '?' or a matching char takes the diagonal
    always_comb
    begin
        next_bit = 1'b0;
        if (active)
        begin
            if (char_reg == STAR_CHAR)
                next_bit = row_reg | left_next;
            else if (char_reg == ANY_CHAR || char_reg == ctrl.text_char)
                next_bit = left_row;
            else
                next_bit = 1'b0;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.restart)
            row_next = (idx <= ctrl.lead);
        else if (ctrl.step_en)
            row_next = next_bit;
    end

    // Match bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= 1'b0;
        else
            row_reg <= row_next;
    end

    // Pattern character, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_pos == idx)
            char_reg <= ctrl.text_char;
    end

endmodule

`default_nettype wire

// ===== hdl/wgm_checker.sv =====
`default_nettype none
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [wgm_pkg::IN_TDATA_W-1:0] s_tdata,   // [1:0] mode, [9:2] char_in
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [wgm_pkg::OUT_TDATA_W-1:0] m_tdata   // [0] matched, [1] overflow
);
    import wgm_pkg::*;

    // Every input transfer produces a result in the next cycle
    `WGM_ASSERT_NEXT(a_result_follows, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // A clear always matches the empty text and never overflows
    `WGM_ASSERT_NEXT(a_clear_matches, clk, rst_n,
        s_tvalid && s_tready && s_tdata[1:0] == MODE_CLEAR, m_tdata[1:0] == 2'b01)

    // Overflow is only raised by an append
    `WGM_ASSERT_NEXT(a_ovf_append_only, clk, rst_n,
        s_tvalid && s_tready && s_tdata[1:0] != MODE_APPEND, !m_tdata[1])

    // A stalled result holds
    `WGM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // Output register full and stalled means no new transfer
    `WGM_ASSERT_NOW(a_no_accept_stalled, clk, rst_n, m_tvalid && !m_tready, !s_tready)

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

`default_nettype wire
